// File: sv/lsts_pkg.sv
// Shared constants for the lazy segment tree range add / range sum block.
// No dependencies.
`timescale 1ns / 1ps

package lsts_pkg;

    localparam int DEF_LEAVES = 65536;
    localparam int IDX_W      = 17;
    localparam int VAL_W      = 32;
    localparam int SUM_W      = 64;
    localparam int PDATA_W    = 32;
    localparam int PADDR_W    = 3;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic REG_ELEMENT_COUNT = 1'b0;

    localparam logic [IDX_W-1:0] COUNT_RESET = IDX_W'(1);

endpackage

// File: sv/lazy_segment_tree_range_add_sum.sv
// Lazy segment tree: range add and range sum over elements 1..element_count.
// An empty interval ends the item at once: an add goes back to idle with no
// result, and a query returns a zero sum. One item at a time.
// Reset: a clearing pass writes zero to every address of both node memories;
// no item is accepted meanwhile, configuration writes are.
`timescale 1ns / 1ps

module lazy_segment_tree_range_add_sum
    import lsts_pkg::*;
#(
    parameter int LEAVES = DEF_LEAVES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input item channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_kind,
    input  logic [IDX_W-1:0]          i_first_index,
    input  logic [IDX_W-1:0]          i_last_index,
    input  logic signed [VAL_W-1:0]   i_add_value,
    // result item channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [SUM_W-1:0]   o_range_sum,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    localparam int AW    = $clog2(LEAVES) + 1;
    localparam int DEPTH = AW;
    localparam int SPW   = $clog2(DEPTH + 1);
    localparam int SIW   = $clog2(DEPTH);
    localparam int NODES = 2 ** AW;

    typedef enum logic [15:0] {
        S_CLEAR  = 16'h0001,
        S_IDLE   = 16'h0002,
        S_RD     = 16'h0004,
        S_LOAD   = 16'h0008,
        S_M1     = 16'h0010,
        S_M2     = 16'h0020,
        S_MADD   = 16'h0040,
        S_CHRD   = 16'h0080,
        S_CHW0   = 16'h0100,
        S_CHW1   = 16'h0200,
        S_DECIDE = 16'h0400,
        S_RET    = 16'h0800,
        S_CMB0   = 16'h1000,
        S_CMB1   = 16'h2000,
        S_CMB2   = 16'h4000,
        S_OUT    = 16'h8000
    } t_state;

    t_state r_state;

    logic [IDX_W-1:0] r_count;
    logic [AW-1:0]    r_clr;
    logic             r_kind;
    logic [IDX_W-1:0] r_a, r_b;
    logic [SUM_W-1:0] r_v;
    logic [AW-1:0]    r_n;
    logic [IDX_W-1:0] r_lo, r_hi;
    logic [SUM_W-1:0] r_sum, r_x, r_acc, r_tmp;
    logic             r_mode;       // 0: settling pending, 1: applying add
    logic [48:0]      r_plo;
    logic [31:0]      r_phi;
    logic [SPW-1:0]   r_sp;
    logic             r_out_valid;
    logic [SUM_W-1:0] r_out_sum;

    // traversal stack, one frame per open tree level
    logic [AW-1:0]    st_n  [DEPTH];
    logic [IDX_W-1:0] st_lo [DEPTH];
    logic [IDX_W-1:0] st_hi [DEPTH];
    logic             st_ph [DEPTH];

    // node memories
    logic [SUM_W-1:0] mem_sum  [NODES];
    logic [SUM_W-1:0] mem_pend [NODES];
    logic [SUM_W-1:0] q_sum, q_pend;

    logic             w_sum_we, w_pend_we;
    logic [AW-1:0]    w_sum_wa, w_pend_wa, w_ra;
    logic [SUM_W-1:0] w_sum_wd, w_pend_wd;

    logic [IDX_W-1:0] w_cnt, w_a, w_b, w_mid, w_len;
    logic [AW-1:0]    w_left, w_right;
    logic [SIW-1:0]   w_top;
    logic             w_in_acc, w_outside, w_full;
    logic [SUM_W-1:0] w_prod, w_msum;

    // effective element count and clipped interval of the offered item
    always_comb begin
        if (r_count == '0) begin
            w_cnt = IDX_W'(1);
        end else if (32'(r_count) > 32'(LEAVES)) begin
            w_cnt = IDX_W'(LEAVES);
        end else begin
            w_cnt = r_count;
        end
        w_a = (i_first_index == '0) ? IDX_W'(1) : i_first_index;
        w_b = (i_last_index > w_cnt) ? w_cnt : i_last_index;
    end

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_mid     = IDX_W'((({1'b0, r_lo} + {1'b0, r_hi}) >> 1));
    assign w_len     = r_hi - r_lo + IDX_W'(1);
    assign w_left    = {r_n[AW-2:0], 1'b0};
    assign w_right   = {r_n[AW-2:0], 1'b1};
    assign w_top     = SIW'(r_sp - SPW'(1));
    assign w_outside = (r_b < r_lo) || (r_a > r_hi);
    assign w_full    = (r_a <= r_lo) && (r_hi <= r_b);
    assign w_prod    = SUM_W'(r_plo) + {r_phi, 32'b0};
    assign w_msum    = r_sum + w_prod;

    // memory port control
    always_comb begin
        w_sum_we  = 1'b0;
        w_pend_we = 1'b0;
        w_sum_wa  = r_n;
        w_pend_wa = r_n;
        w_sum_wd  = '0;
        w_pend_wd = '0;
        w_ra      = r_n;
        case (r_state)
            S_CLEAR: begin
                w_sum_we  = 1'b1;
                w_pend_we = 1'b1;
                w_sum_wa  = r_clr;
                w_pend_wa = r_clr;
            end
            S_MADD: begin
                w_sum_we  = 1'b1;
                w_pend_we = 1'b1;
                w_sum_wd  = w_msum;
            end
            S_CHRD: w_ra = w_left;
            S_CHW0: begin
                w_pend_we = 1'b1;
                w_pend_wa = w_left;
                w_pend_wd = q_pend + r_x;
                w_ra      = w_right;
            end
            S_CHW1: begin
                w_pend_we = 1'b1;
                w_pend_wa = w_right;
                w_pend_wd = q_pend + r_x;
            end
            S_CMB0: w_ra = w_left;
            S_CMB1: w_ra = w_right;
            S_CMB2: begin
                w_sum_we = 1'b1;
                w_sum_wd = r_tmp + q_sum;
            end
            default: w_ra = r_n;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_sum_we) begin
            mem_sum[w_sum_wa] <= w_sum_wd;
        end
        if (w_pend_we) begin
            mem_pend[w_pend_wa] <= w_pend_wd;
        end
        q_sum  <= mem_sum[w_ra];
        q_pend <= mem_pend[w_ra];
    end

    // configuration register
    assign pready = 1'b1;
    assign prdata = PDATA_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT)) begin
            r_count <= pwdata[IDX_W-1:0];
        end
    end

    // node sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(NODES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_kind <= i_kind;
                        r_a    <= w_a;
                        r_b    <= w_b;
                        r_v    <= SUM_W'(i_add_value);
                        r_n    <= AW'(1);
                        r_lo   <= IDX_W'(1);
                        r_hi   <= w_cnt;
                        r_acc  <= '0;
                        r_sp   <= '0;
                        if (w_a > w_b) begin
                            r_state <= (i_kind == KIND_QUERY) ? S_OUT : S_IDLE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_LOAD;
                S_LOAD: begin
                    r_sum  <= q_sum;
                    r_x    <= q_pend;
                    r_mode <= 1'b0;
                    r_state <= (q_pend != '0) ? S_M1 : S_DECIDE;
                end
                S_M1: begin
                    r_plo   <= 49'(w_len) * 49'(r_x[31:0]);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_phi   <= 32'(49'(w_len) * 49'(r_x[63:32]));
                    r_state <= S_MADD;
                end
                S_MADD: begin
                    r_sum <= w_msum;
                    if (r_lo != r_hi) begin
                        r_state <= S_CHRD;
                    end else begin
                        r_state <= r_mode ? S_RET : S_DECIDE;
                    end
                end
                S_CHRD: r_state <= S_CHW0;
                S_CHW0: r_state <= S_CHW1;
                S_CHW1: r_state <= r_mode ? S_RET : S_DECIDE;
                S_DECIDE: begin
                    if (w_outside) begin
                        r_state <= S_RET;
                    end else if (w_full) begin
                        if (r_kind == KIND_QUERY) begin
                            r_acc   <= r_acc + r_sum;
                            r_state <= S_RET;
                        end else begin
                            r_x     <= r_v;
                            r_mode  <= 1'b1;
                            r_state <= S_M1;
                        end
                    end else begin
                        // open this node and descend left
                        st_n[r_sp[SIW-1:0]]  <= r_n;
                        st_lo[r_sp[SIW-1:0]] <= r_lo;
                        st_hi[r_sp[SIW-1:0]] <= r_hi;
                        st_ph[r_sp[SIW-1:0]] <= 1'b0;
                        r_sp    <= r_sp + SPW'(1);
                        r_n     <= w_left;
                        r_hi    <= w_mid;
                        r_state <= S_RD;
                    end
                end
                S_RET: begin
                    if (r_sp == '0) begin
                        r_state <= (r_kind == KIND_QUERY) ? S_OUT : S_IDLE;
                    end else if (!st_ph[w_top]) begin
                        // left done: descend right
                        st_ph[w_top] <= 1'b1;
                        r_n     <= {st_n[w_top][AW-2:0], 1'b1};
                        r_lo    <= IDX_W'((({1'b0, st_lo[w_top]}
                                           + {1'b0, st_hi[w_top]}) >> 1) + 18'd1);
                        r_hi    <= st_hi[w_top];
                        r_state <= S_RD;
                    end else begin
                        // both children done: close the node
                        r_n     <= st_n[w_top];
                        r_lo    <= st_lo[w_top];
                        r_hi    <= st_hi[w_top];
                        r_sp    <= r_sp - SPW'(1);
                        r_state <= (r_kind == KIND_QUERY) ? S_RET : S_CMB0;
                    end
                end
                S_CMB0: r_state <= S_CMB1;
                S_CMB1: begin
                    r_tmp   <= q_sum;
                    r_state <= S_CMB2;
                end
                S_CMB2: r_state <= S_RET;
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_sum   <= r_acc;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_out_sum;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(DEPTH))
        else $error("traversal stack overflow");

    a_leaf_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHRD) |-> (r_lo != r_hi))
        else $error("leaf node pushes pending to children");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the done state");

    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (o_in_stall || $past(r_clr == AW'(NODES - 1))))
        else $error("item accepted during clearing pass");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for lazy_segment_tree_range_add_sum: range adds and
// range sums checked against an in-bench lazy segment tree predictor.
// Depends on lsts_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
    import lsts_pkg::*;

    localparam int TREE_NODES  = 2 * DEF_LEAVES;
    localparam int SETTLE_CYC  = 1000;
    localparam int STALL_LIMIT = 400000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_kind;
    logic [IDX_W-1:0]        i_first_index;
    logic [IDX_W-1:0]        i_last_index;
    logic signed [VAL_W-1:0] i_add_value;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [SUM_W-1:0] o_range_sum;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PDATA_W-1:0]      pwdata;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    lazy_segment_tree_range_add_sum DUT (.*);

    // Predictor state: node sums, pending adds, element count register
    bit [63:0]      seg_sum[TREE_NODES];
    bit [63:0]      seg_lazy[TREE_NODES];
    bit [IDX_W-1:0] count_reg;
    bit [63:0]      expected_sums[$];

    int  fail_count;
    bit  no_idle;
    bit  hold_req;
    int  hold_left;
    int  rx_run;
    bit  rx_stalling;

    // Clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic bit [63:0] live_count();
        if (count_reg == 0) return 64'd1;
        if (count_reg > DEF_LEAVES) return 64'(DEF_LEAVES);
        return 64'(count_reg);
    endfunction

    // Apply a node's pending amount and hand it to its children
    function automatic void push_lazy(int n, bit [63:0] lo, bit [63:0] hi);
        bit [63:0] p;
        p = seg_lazy[n];
        if (p != 0) begin
            seg_sum[n] += (hi - lo + 64'd1) * p;
            if (lo != hi) begin
                seg_lazy[2*n]   += p;
                seg_lazy[2*n+1] += p;
            end
            seg_lazy[n] = 0;
        end
    endfunction

    function automatic void tree_add(int n, bit [63:0] lo, bit [63:0] hi,
                                     bit [63:0] a, bit [63:0] b, bit [63:0] v);
        bit [63:0] mid;
        push_lazy(n, lo, hi);
        if (b < lo || a > hi) return;
        if (a <= lo && hi <= b) begin
            seg_sum[n] += (hi - lo + 64'd1) * v;
            if (lo != hi) begin
                seg_lazy[2*n]   += v;
                seg_lazy[2*n+1] += v;
            end
            return;
        end
        mid = (lo + hi) / 2;
        tree_add(2*n, lo, mid, a, b, v);
        tree_add(2*n+1, mid + 1, hi, a, b, v);
        seg_sum[n] = seg_sum[2*n] + seg_sum[2*n+1];
    endfunction

    function automatic bit [63:0] tree_sum(int n, bit [63:0] lo, bit [63:0] hi,
                                           bit [63:0] a, bit [63:0] b);
        bit [63:0] mid;
        push_lazy(n, lo, hi);
        if (b < lo || a > hi) return 64'd0;
        if (a <= lo && hi <= b) return seg_sum[n];
        mid = (lo + hi) / 2;
        return tree_sum(2*n, lo, mid, a, b) + tree_sum(2*n+1, mid + 1, hi, a, b);
    endfunction

    // Clip the interval, update the tree, queue the sum a query produces
    function automatic void predict_item(bit k, bit [IDX_W-1:0] f,
                                         bit [IDX_W-1:0] l, bit [VAL_W-1:0] v);
        bit [63:0] cnt;
        bit [63:0] a;
        bit [63:0] b;
        cnt = live_count();
        a = (f < 1) ? 64'd1 : 64'(f);
        b = (64'(l) > cnt) ? cnt : 64'(l);
        if (k == KIND_ADD) begin
            if (a <= b) tree_add(1, 64'd1, cnt, a, b, {{32{v[31]}}, v});
        end else begin
            expected_sums.push_back((a <= b) ? tree_sum(1, 64'd1, cnt, a, b) : 64'd0);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_item(bit k, bit [IDX_W-1:0] f, bit [IDX_W-1:0] l,
                             bit [VAL_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= k;
        i_first_index <= f;
        i_last_index  <= l;
        i_add_value   <= v;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(k, f, l, v);
    endtask

    // Drop valid, wait for every expected sum and for the block to go idle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Setup-then-enable register write on an idle block
    task automatic set_count(bit [IDX_W-1:0] cnt);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_ELEMENT_COUNT);
        pwdata  <= PDATA_W'(cnt);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        count_reg = cnt;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        bit [IDX_W-1:0] f;
        bit [IDX_W-1:0] l;
        bit [IDX_W-1:0] t;
        bit [VAL_W-1:0] v;
        int             cnt;
        int             r;
        cnt = int'(live_count());
        r = $urandom_range(0, 19);
        f = IDX_W'($urandom_range(1, cnt));
        l = IDX_W'($urandom_range(1, cnt));
        if (f > l) begin
            t = f;
            f = l;
            l = t;
        end
        if (r == 18) begin
            f = IDX_W'($urandom);
            l = IDX_W'($urandom);
        end else if (r == 19) begin
            l = IDX_W'($urandom_range(cnt, cnt + 3));
            f = IDX_W'($urandom_range(0, 2));
        end
        v = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom_range(0, 200) - 100) : $urandom;
        send_item($urandom_range(0, 1) ? KIND_QUERY : KIND_ADD, f, l, v);
    endtask

    task automatic test_directed();
        // reset count of one element
        send_item(KIND_ADD, 1, 1, 32'h7FFF_FFFF);
        send_item(KIND_QUERY, 1, 1, 0);
        send_item(KIND_QUERY, 0, 17'h1FFFF, 0);
        set_count(17'd65536);
        send_item(KIND_ADD, 1, 65536, 32'h8000_0000);
        send_item(KIND_ADD, 1, 65536, 32'h8000_0000);
        send_item(KIND_QUERY, 1, 65536, 0);
        send_item(KIND_ADD, 65536, 65536, 32'hFFFF_FFFF);
        send_item(KIND_ADD, 0, 0, 32'h1234_5678);
        send_item(KIND_ADD, 9, 8, 32'h1234_5678);
        send_item(KIND_QUERY, 9, 8, 0);
        send_item(KIND_QUERY, 17'h1FFFF, 17'h1FFFF, 0);
        send_item(KIND_QUERY, 0, 17'h1FFFF, 0);
        send_item(KIND_ADD, 100, 40000, 32'h7FFF_FFFF);
        send_item(KIND_QUERY, 32768, 32769, 0);
        send_item(KIND_QUERY, 1, 1, 32'hFFFF_FFFF);
        // saturation to the largest tree, then zero counting as one
        set_count(17'h1FFFF);
        send_item(KIND_QUERY, 1, 65536, 0);
        send_item(KIND_QUERY, 65535, 17'h1FFFF, 0);
        set_count(17'd0);
        send_item(KIND_ADD, 1, 2, 32'd5);
        send_item(KIND_QUERY, 1, 2, 0);
        send_item(KIND_QUERY, 2, 2, 0);
        set_count(17'd37);
        send_item(KIND_QUERY, 1, 37, 0);
        send_item(KIND_QUERY, 20, 38, 0);
    endtask

    task automatic test_random_small();
        repeat (6) begin
            set_count(IDX_W'($urandom_range(2, 200)));
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (180) random_item();
            no_idle = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        set_count(17'd50);
        hold_req = 1'b1;
        repeat (60) send_item(KIND_QUERY, IDX_W'($urandom_range(1, 25)),
                              IDX_W'($urandom_range(25, 60)), 0);
        // sender waits for every result before going on
        i_in_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (30) random_item();
    endtask

    task automatic test_random_large();
        set_count(17'd65536);
        repeat (70) random_item();
        set_count(IDX_W'($urandom_range(30000, 65535)));
        repeat (50) random_item();
        set_count(17'd1);
        repeat (20) random_item();
        set_count(IDX_W'($urandom_range(2, 16)));
        repeat (100) random_item();
    endtask

    // Check each sum against the oldest expectation; pace the receiver
    always @(posedge i_clk) begin
        bit [63:0] want;
        if (o_out_valid && !i_out_stall) begin
            if (expected_sums.size() == 0) begin
                $error("unexpected result: range_sum actual %h", o_range_sum);
                fail_count++;
            end else begin
                want = expected_sums.pop_front();
                if (o_range_sum !== want) begin
                    $error("range_sum mismatch: expected %h actual %h", want, o_range_sum);
                    fail_count++;
                end
            end
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_stalling = !no_idle && ($urandom_range(0, 2) == 0);
                rx_run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(1, 3);
            end
            rx_run--;
            i_out_stall <= rx_stalling;
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin
        int quiet;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
        else quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_kind        <= KIND_ADD;
        i_first_index <= '0;
        i_last_index  <= '0;
        i_add_value   <= '0;
        i_out_stall   <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        count_reg     = COUNT_RESET;
        fail_count    = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_small();
        test_backpressure();
        test_random_large();

        drain();
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: lazy_segment_tree_range_add_sum.f
sv/lsts_pkg.sv
sv/lazy_segment_tree_range_add_sum.sv
tb/tb_top.sv
